/* sv/gf4096_mul_inv_dot_unit_assert.svh */
`ifndef GF4096_MUL_INV_DOT_UNIT_ASSERT_SVH
`define GF4096_MUL_INV_DOT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define GFMID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gfmid: assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define GFMID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gfmid: assertion failed");

`endif

/* sv/gfmid_pkg.sv */
package gfmid_pkg;

	localparam int FieldW = 12;
	localparam int OpW    = 2;

	// inverse = a^4094 via a fixed chain of 16 multiplier passes
	localparam int InvSteps = 16;
	localparam int StepW    = $clog2(InvSteps);
	localparam logic [StepW-1:0] LastStep = StepW'(InvSteps - 1);
	localparam logic [StepW-1:0] StepP3   = StepW'(1);
	localparam logic [StepW-1:0] StepP7   = StepW'(3);
	localparam logic [StepW-1:0] StepP15  = StepW'(5);
	localparam logic [StepW-1:0] StepP255 = StepW'(10);
	localparam logic [StepW-1:0] StepP2047 = StepW'(14);

	typedef logic [FieldW-1:0] field_t;

	typedef enum logic [OpW-1:0] {
		OP_MUL  = 2'd0,
		OP_INV  = 2'd1,
		OP_DOT  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// second multiplier operand during the inverse chain
	typedef enum logic [1:0] {
		BSEL_SELF,
		BSEL_A,
		BSEL_T7,
		BSEL_T15
	} bsel_t;

	typedef struct packed {
		logic  start_inv;
		logic  inv_step;
		bsel_t bsel;
		logic  save7;
		logic  save15;
		logic  dot_step;
		logic  dot_last;
		logic  out_load;
		logic  out_acc;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// carry-less 12x12 product reduced by x^12 = x^3 + 1
	function automatic field_t gf_mul(input field_t a, input field_t b);
		logic [2*FieldW-2:0] prod;
		logic [FieldW-2:0]   hi;
		logic [1:0]          wrap;
		logic [FieldW+1:0]   fold;
		prod = '0;
		for (int i = 0; i < FieldW; i++) begin
			if (b[i]) begin
				prod = prod ^ ((2*FieldW-1)'(a) << i);
			end
		end
		hi   = prod[2*FieldW-2:FieldW];
		fold = (FieldW+2)'(hi) ^ ((FieldW+2)'(hi) << 3);
		wrap = fold[FieldW+1:FieldW];
		return prod[FieldW-1:0] ^ fold[FieldW-1:0]
			^ FieldW'(wrap) ^ (FieldW'(wrap) << 3);
	endfunction

endpackage

/* sv/gfmid_if.sv */
interface gfmid_in_if import gfmid_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OpW-1:0]    opcode;
	logic [FieldW-1:0] operand_a;
	logic [FieldW-1:0] operand_b;
	logic              last;

	modport source (output valid, output opcode, output operand_a, output operand_b,
		output last, input ready);
	modport sink (input valid, input opcode, input operand_a, input operand_b,
		input last, output ready);
endinterface

interface gfmid_out_if import gfmid_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FieldW-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

/* sv/gfmid_ctrl.sv */
module gfmid_ctrl import gfmid_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [OpW-1:0] in_opcode,
	input  logic           in_last,
	output logic           in_ready,
	input  dp_stat_t       stat,
	output dp_cmd_t        cmd
);

	typedef enum logic {
		S_IDLE,
		S_INV
	} state_t;

	state_t           state_q;
	logic [StepW-1:0] step_q;
	logic             accept;
	op_t              op;

	assign op       = op_t'(in_opcode);
	assign in_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.bsel = BSEL_SELF;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_MUL: cmd.out_load = 1'b1;
						OP_INV: cmd.start_inv = 1'b1;
						OP_DOT: begin
							cmd.dot_step = 1'b1;
							cmd.dot_last = in_last;
							cmd.out_load = in_last;
							cmd.out_acc  = 1'b1;
						end
						OP_NONE: ;
					endcase
				end
			end
			S_INV: begin
				// final pass writes the output register, so it waits for room
				cmd.inv_step = (step_q != LastStep) || stat.out_free;
				cmd.save7    = (step_q == StepP7);
				cmd.save15   = (step_q == StepP15);
				cmd.out_load = (step_q == LastStep) && stat.out_free;
				priority if (step_q == StepP255) begin
					cmd.bsel = BSEL_T15;
				end else if (step_q == StepP2047) begin
					cmd.bsel = BSEL_T7;
				end else if (step_q == StepP3 || step_q == StepP7 || step_q == StepP15) begin
					cmd.bsel = BSEL_A;
				end else begin
					cmd.bsel = BSEL_SELF;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && op == OP_INV) begin
						state_q <= S_INV;
						step_q  <= '0;
					end
				end
				S_INV: begin
					if (cmd.inv_step) begin
						if (step_q == LastStep) begin
							state_q <= S_IDLE;
						end
						step_q <= step_q + StepW'(1);
					end
				end
			endcase
		end
	end

endmodule

/* sv/gfmid_dp.sv */
module gfmid_dp import gfmid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  field_t      operand_a,
	input  field_t      operand_b,
	output dp_stat_t    stat,
	gfmid_out_if.source dout
);

	field_t a_q;
	field_t r_q;
	field_t t7_q;
	field_t t15_q;
	field_t acc_q;
	field_t res_q;
	logic   res_valid_q;
	field_t mul_a;
	field_t mul_b;
	field_t sel_b;
	field_t prod;

	always_comb begin
		unique case (cmd.bsel)
			BSEL_SELF: sel_b = r_q;
			BSEL_A:    sel_b = a_q;
			BSEL_T7:   sel_b = t7_q;
			BSEL_T15:  sel_b = t15_q;
		endcase
	end

	// one shared multiplier: input operands or the inverse chain
	assign mul_a = cmd.inv_step ? r_q : operand_a;
	assign mul_b = cmd.inv_step ? sel_b : operand_b;
	assign prod  = gf_mul(mul_a, mul_b);

	assign stat.out_free = !res_valid_q || dout.ready;
	assign dout.valid    = res_valid_q;
	assign dout.result   = res_q;

	always_ff @(posedge clk) begin
		if (cmd.start_inv) begin
			a_q <= operand_a;
			r_q <= operand_a;
		end else if (cmd.inv_step) begin
			r_q <= prod;
		end
		if (cmd.inv_step && cmd.save7) begin
			t7_q <= prod;
		end
		if (cmd.inv_step && cmd.save15) begin
			t15_q <= prod;
		end
		if (cmd.out_load) begin
			res_q <= cmd.out_acc ? (acc_q ^ prod) : prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.dot_step) begin
				acc_q <= cmd.dot_last ? '0 : (acc_q ^ prod);
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (dout.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/gf4096_mul_inv_dot_unit.sv */
// GF(2^12) arithmetic unit, field polynomial x^12 + x^3 + 1.
// Channel din carries one transaction per operation: opcode, operand_a,
// operand_b, last. Channel dout carries result transactions.
// Multiply: one result, visible in the cycle after acceptance; one
// transaction per cycle while dout keeps up.
// Dot step: XORs a*b into an accumulator, one transaction per cycle while
// dout keeps up; the last step returns the sum next cycle and clears it.
// Inverse (a^4094, zero maps to zero): 16 passes through the single shared
// multiplier, the last one loading the output register; din is not ready
// meanwhile, so the next transaction is taken only after the last pass.
// Opcode 3 is dropped with no result and no state change.
// Results sit in one output register: outside an inverse, din stays ready
// while that register is empty or being drained in the same cycle; a
// stalled dout holds its transaction and back-pressures din. The last
// inverse pass waits likewise. Reset (arst_n low) clears the accumulator,
// the output register valid and the sequencer; no clearing pass is needed.
module gf4096_mul_inv_dot_unit import gfmid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	gfmid_in_if.sink    din,
	gfmid_out_if.source dout
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ready;

	assign din.ready = ready;

	gfmid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_opcode (din.opcode),
		.in_last   (din.last),
		.in_ready  (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gfmid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operand_a (din.operand_a),
		.operand_b (din.operand_b),
		.stat      (stat),
		.dout      (dout)
	);

endmodule

/* sv/gfmid_checker.sv */
`include "gf4096_mul_inv_dot_unit_assert.svh"

module gfmid_checker import gfmid_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OpW-1:0]    in_opcode,
	input logic              out_valid,
	input logic              out_ready,
	input logic [FieldW-1:0] out_result
);

	logic in_fire;

	assign in_fire = in_valid && in_ready;

	`GFMID_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`GFMID_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_result))
	`GFMID_ASSERT_NEXT(a_mul_result, clk, arst_n, in_fire && in_opcode == OP_MUL, out_valid)
	`GFMID_ASSERT_NEXT(a_inv_busy, clk, arst_n, in_fire && in_opcode == OP_INV, !in_ready)
	`GFMID_ASSERT_NOW(a_no_fire_stalled, clk, arst_n, out_valid && !out_ready, !in_ready)

endmodule

bind gf4096_mul_inv_dot_unit gfmid_checker u_gfmid_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (din.valid),
	.in_ready   (din.ready),
	.in_opcode  (din.opcode),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.out_result (dout.result)
);

/* sim/gf4096_mul_inv_dot_unit_chk.sv */
module gf4096_mul_inv_dot_unit_chk import gfmid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gfmid_in_if  din,
	gfmid_out_if dout,
	output int   mismatch_count,
	output int   pending
);

	// x^12 = x^3 + 1
	localparam field_t FIELD_TAIL = 12'h009;
	localparam field_t INV_EXP    = 12'd4094;
	localparam int     REPORT_MAX = 10;

	field_t results_due[$];
	field_t dot_sum;

	// Horner-style: walk b from its top bit, doubling the partial product
	function automatic field_t field_mul(input field_t a, input field_t b);
		field_t p = '0;
		for (int i = FieldW - 1; i >= 0; i--) begin
			p = {p[FieldW-2:0], 1'b0} ^ (p[FieldW-1] ? FIELD_TAIL : field_t'(0));
			if (b[i]) begin
				p = p ^ a;
			end
		end
		return p;
	endfunction

	// a^4094 by right-to-left square and multiply; zero stays zero
	function automatic field_t field_inv(input field_t a);
		field_t r  = field_t'(1);
		field_t sq = a;
		for (int i = 0; i < FieldW; i++) begin
			if (INV_EXP[i]) begin
				r = field_mul(r, sq);
			end
			sq = field_mul(sq, sq);
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input field_t want, input field_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$display("%0t: %s: expected result 0x%03h, got 0x%03h", $realtime, what, want, got);
		end
	endtask

	initial begin
		mismatch_count = 0;
		pending        = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		field_t want;
		field_t sum;
		if (!arst_n) begin
			results_due.delete();
			dot_sum = '0;
			pending = 0;
		end else begin
			if (dout.valid && dout.ready) begin
				if (results_due.size() == 0) begin
					note_mismatch("unexpected transaction", '0, dout.result);
				end else begin
					want = results_due.pop_front();
					if (dout.result !== want) begin
						note_mismatch("wrong result", want, dout.result);
					end
				end
			end
			if (din.valid && din.ready) begin
				case (op_t'(din.opcode))
					OP_MUL: results_due.push_back(field_mul(din.operand_a, din.operand_b));
					OP_INV: results_due.push_back(field_inv(din.operand_a));
					OP_DOT: begin
						sum = dot_sum ^ field_mul(din.operand_a, din.operand_b);
						if (din.last) begin
							results_due.push_back(sum);
							dot_sum = '0;
						end else begin
							dot_sum = sum;
						end
					end
					default: ;
				endcase
			end
			pending = results_due.size();
		end
	end

endmodule

/* sim/gf4096_mul_inv_dot_unit_tb.sv */
module gf4096_mul_inv_dot_unit_tb import gfmid_pkg::*; ();

	localparam int PHASE_ITEMS = 425;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 40;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatch_count;
	int   pending;
	int   src_idle   = 0;
	int   sink_stall = 0;
	int   cycle_count;

	gfmid_in_if  din();
	gfmid_out_if dout();

	gf4096_mul_inv_dot_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	gf4096_mul_inv_dot_unit_chk chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.din            (din),
		.dout           (dout),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		dout.ready = ($urandom_range(99) >= sink_stall);
	end

	// called and returns at a falling edge
	task automatic send(input op_t op, input field_t a, input field_t b, input logic last);
		while ($urandom_range(99) < src_idle) begin
			din.valid = 1'b0;
			@(negedge clk);
		end
		din.valid     = 1'b1;
		din.opcode    = op;
		din.operand_a = a;
		din.operand_b = b;
		din.last      = last;
		do @(posedge clk); while (!din.ready);
		@(negedge clk);
	endtask

	function automatic field_t pick_operand();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return field_t'(1);
			default: return field_t'($urandom);
		endcase
	endfunction

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int   sent;
		int   pick;
		op_t  op;
		arst_n        = 1'b0;
		din.valid     = 1'b0;
		din.opcode    = OP_MUL;
		din.operand_a = '0;
		din.operand_b = '0;
		din.last      = 1'b0;
		dout.ready    = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// extremes of multiply and inverse
		send(OP_MUL, 12'h000, 12'h000, 1'b0);
		send(OP_MUL, 12'hfff, 12'hfff, 1'b0);
		send(OP_MUL, 12'h001, 12'ha5c, 1'b0);
		send(OP_MUL, 12'h800, 12'h800, 1'b1);
		send(OP_INV, 12'h000, 12'hfff, 1'b0);
		send(OP_INV, 12'h001, 12'h000, 1'b1);
		send(OP_INV, 12'hfff, 12'h123, 1'b0);
		send(OP_INV, 12'h800, 12'h000, 1'b0);
		send(OP_INV, 12'h002, 12'h000, 1'b0);
		// dot vector with a dropped opcode and a multiply mixed in
		send(OP_DOT, 12'h003, 12'h005, 1'b0);
		send(OP_DOT, 12'hfff, 12'hfff, 1'b0);
		send(OP_NONE, 12'hfff, 12'hfff, 1'b1);
		send(OP_MUL, 12'h007, 12'h009, 1'b1);
		send(OP_DOT, 12'h800, 12'h002, 1'b1);
		// single-pair vector, then a dropped opcode with last low
		send(OP_DOT, 12'hfff, 12'h001, 1'b1);
		send(OP_NONE, 12'h000, 12'h000, 1'b0);
		send(OP_DOT, 12'h000, 12'hfff, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 57; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 57; end
				default: begin src_idle = 32; sink_stall = 32; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				op = (pick < 30) ? OP_MUL : (pick < 40) ? OP_INV :
					(pick < 45) ? OP_NONE : OP_DOT;
				send(op, pick_operand(), pick_operand(), ($urandom_range(3) == 0));
				if (op != OP_NONE) begin
					sent++;
				end
			end
			// hold off until the unit has drained
			if (phase == 1) begin
				din.valid = 1'b0;
				while (pending != 0) @(negedge clk);
			end
		end

		din.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
